/* rtl/core/rgbcf_pkg.sv */
package rgbcf_pkg;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int TAPS      = 9;
    localparam int COEF_W    = 4;
    localparam int KERNEL_W  = TAPS * COEF_W;
    localparam int DIVISOR_W = 8;
    localparam int FW_W      = 11;
    localparam int FH_W      = 16;
    localparam int ITEM_W    = 27;
    localparam int SUM_W     = 16;
    localparam int PROD_W    = COEF_W + CH_W + 1;
    localparam int EDGE_W    = SUM_W + 2;
    localparam int ABS_W     = SUM_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = KERNEL_W;

    localparam int EDGE_THRESHOLD = 384;
    localparam int PIXEL_MAX      = 255;
    // floor(a/3) == (a * 43691) >> 17 for a below 2^16
    localparam int THIRD_RECIP    = 43691;
    localparam int THIRD_SHIFT    = 17;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd3;

    localparam logic [KERNEL_W-1:0]  KERNEL_RESET  = 36'h111111111;
    localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 8'd9;
    localparam logic [FW_W-1:0]      WIDTH_RESET   = 11'd1024;
    localparam logic [FH_W-1:0]      HEIGHT_RESET  = 16'd768;

    // shared divider: item position by width, channel sum by divisor
    localparam int DIVN_W = ITEM_W;
    localparam int DIVD_W = FW_W;
    localparam int DIVC_W = 5;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [KERNEL_W-1:0]  kernel;
        logic [DIVISOR_W-1:0] divisor;
        logic [FW_W-1:0]      w_eff;
        logic [FH_W-1:0]      h_eff;
    } cfg_t;

    typedef struct packed {
        pixel_t [TAPS-1:0]   win;
        logic [ITEM_W-1:0]   pos;
        logic                last;
    } work_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } result_t;

endpackage

/* rtl/core/rgb_3x3_convolution_filter_top.sv */
// 3x3 RGB convolution filter.
// Input queue: push/full with red_in, green_in, blue_in and filler; a pixel
// is taken when push is high and full is low. Results: empty/pop with
// red_out, green_out, blue_out and last_of_frame; the oldest result is
// shown while empty is low. Config: cfg_valid/cfg_ready with cfg_index
// (0 kernel, 1 divisor, 2 width, 3 height) and cfg_data; cfg_ready is
// always high.
// The front takes a pixel and reads the line stores, then rotates them
// and pushes into a 2-entry work queue before it takes the next. The
// back handles one request at a time through a shared restoring
// divider: position split into row/column, 9 taps, then either up to
// three channel divisions or edge logic. Sustained rate is set by
// that divider loop.
// After reset the line stores are cleared, one entry per cycle across
// all MAX_WIDTH entries, with full held high. When the receiver stalls, the
// 2-entry result queue and the work queue fill and full rises.
module rgb_3x3_convolution_filter_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [7:0]                            red_in,
    input  logic [7:0]                            green_in,
    input  logic [7:0]                            blue_in,
    input  logic                                  filler,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [7:0]                            red_out,
    output logic [7:0]                            green_out,
    output logic [7:0]                            blue_out,
    output logic                                  last_of_frame,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rgbcf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rgbcf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [rgbcf_pkg::KERNEL_W-1:0]  kernel_reg;
    logic [rgbcf_pkg::DIVISOR_W-1:0] divisor_reg;
    logic [rgbcf_pkg::FW_W-1:0]      width_reg;
    logic [rgbcf_pkg::FH_W-1:0]      height_reg;
    rgbcf_pkg::cfg_t                 cfg;

    logic               wq_push, wq_full, wq_pop, wq_empty;
    rgbcf_pkg::work_t   wq_din, wq_dout;
    logic               rq_push, rq_full;
    rgbcf_pkg::result_t rq_din, rq_dout;

    assign cfg_ready   = 1'b1;

    always_comb
    begin
        cfg.kernel  = kernel_reg;
        cfg.divisor = divisor_reg;
        cfg.h_eff   = (height_reg == '0) ? rgbcf_pkg::FH_W'(1) : height_reg;
        if (width_reg == '0)
        begin
            cfg.w_eff = rgbcf_pkg::FW_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            cfg.w_eff = rgbcf_pkg::FW_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.w_eff = width_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg  <= rgbcf_pkg::KERNEL_RESET;
            divisor_reg <= rgbcf_pkg::DIVISOR_RESET;
            width_reg   <= rgbcf_pkg::WIDTH_RESET;
            height_reg  <= rgbcf_pkg::HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rgbcf_pkg::REG_KERNEL:  kernel_reg  <= cfg_data;
                rgbcf_pkg::REG_DIVISOR: divisor_reg <= cfg_data[rgbcf_pkg::DIVISOR_W-1:0];
                rgbcf_pkg::REG_WIDTH:   width_reg   <= cfg_data[rgbcf_pkg::FW_W-1:0];
                rgbcf_pkg::REG_HEIGHT:  height_reg  <= cfg_data[rgbcf_pkg::FH_W-1:0];
                default:                kernel_reg  <= kernel_reg;
            endcase
        end
    end

    rgbcf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .filler   (filler),
        .cfg      (cfg),
        .q_push   (wq_push),
        .q_data   (wq_din),
        .q_full   (wq_full)
    );

    rgbcf_fifo #(.WIDTH($bits(rgbcf_pkg::work_t)), .DEPTH(2)) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (wq_push),
        .full  (wq_full),
        .din   (wq_din),
        .pop   (wq_pop),
        .empty (wq_empty),
        .dout  (wq_dout)
    );

    rgbcf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (wq_empty),
        .q_pop   (wq_pop),
        .q_data  (wq_dout),
        .o_push  (rq_push),
        .o_data  (rq_din),
        .o_full  (rq_full)
    );

    rgbcf_fifo #(.WIDTH($bits(rgbcf_pkg::result_t)), .DEPTH(2)) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .full  (rq_full),
        .din   (rq_din),
        .pop   (pop),
        .empty (empty),
        .dout  (rq_dout)
    );

    assign red_out       = rq_dout.red;
    assign green_out     = rq_dout.green;
    assign blue_out      = rq_dout.blue;
    assign last_of_frame = rq_dout.last;

endmodule

/* rtl/core/rgbcf_fifo.sv */
module rgbcf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/rgbcf_front.sv */
module rgbcf_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          red_in,
    input  logic [7:0]          green_in,
    input  logic [7:0]          blue_in,
    input  logic                filler,
    input  rgbcf_pkg::cfg_t     cfg,
    output logic                q_push,
    output rgbcf_pkg::work_t    q_data,
    input  logic                q_full
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int IW    = rgbcf_pkg::ITEM_W;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROC} state_t;

    state_t                          state_reg;
    logic [COL_W-1:0]                col_reg, clr_reg;
    logic [IW-1:0]                   items_reg;
    rgbcf_pkg::pixel_t [rgbcf_pkg::TAPS-1:0] win_reg, win_next;
    rgbcf_pkg::pixel_t               px_reg, up_rd_reg, mid_rd_reg;
    rgbcf_pkg::pixel_t               upper_mem  [MAX_WIDTH];
    rgbcf_pkg::pixel_t               middle_mem [MAX_WIDTH];

    logic            accept;
    logic [COL_W:0]  col_plus;
    logic            col_wrap;
    logic [IW:0]     items_thr;
    logic            have_out;
    logic [IW-1:0]   pos, total;
    logic            last;

    assign full   = (state_reg != S_IDLE) || q_full;
    assign accept = push && !full;

    assign col_plus  = {1'b0, col_reg} + 1'b1;
    assign col_wrap  = 32'(col_plus) >= 32'(cfg.w_eff);
    assign items_thr = (IW + 1)'(cfg.w_eff) + 1'b1;
    assign have_out  = {1'b0, items_reg} >= items_thr;
    assign pos       = items_reg - items_thr[IW-1:0];
    assign total     = IW'(cfg.w_eff) * IW'(cfg.h_eff);
    assign last      = pos >= total - 1'b1;

    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = up_rd_reg;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid_rd_reg;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = px_reg;
    end

    assign q_push      = (state_reg == S_PROC) && have_out;
    assign q_data.win  = win_next;
    assign q_data.pos  = pos;
    assign q_data.last = last;

    // line stores rotate: middle row moves up, new pixel takes its place
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            upper_mem[clr_reg]  <= '0;
            middle_mem[clr_reg] <= '0;
        end
        else if (state_reg == S_PROC)
        begin
            upper_mem[col_reg]  <= mid_rd_reg;
            middle_mem[col_reg] <= px_reg;
        end
        if (accept)
        begin
            up_rd_reg  <= upper_mem[col_reg];
            mid_rd_reg <= middle_mem[col_reg];
            px_reg     <= filler ? '0 : {red_in, green_in, blue_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            col_reg   <= '0;
            clr_reg   <= '0;
            items_reg <= '0;
            win_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == COL_W'(MAX_WIDTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_PROC;
                    end
                end
                S_PROC:
                begin
                    win_reg <= win_next;
                    if (col_wrap || (have_out && last))
                    begin
                        col_reg <= '0;
                    end
                    else
                    begin
                        col_reg <= col_plus[COL_W-1:0];
                    end
                    items_reg <= (have_out && last) ? '0 : items_reg + 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> full)
        else $error("input open during line store clear");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("work request pushed into full queue");

    a_accept_proc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_PROC)
        else $error("accepted request not processed");

endmodule

/* rtl/core/rgbcf_div.sv */
module rgbcf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rgbcf_pkg::DIVN_W-1:0] num,
    input  logic [rgbcf_pkg::DIVD_W-1:0] den,
    output logic                         done,
    output logic [rgbcf_pkg::DIVN_W-1:0] quo,
    output logic [rgbcf_pkg::DIVD_W-1:0] rem
);

    localparam int NW = rgbcf_pkg::DIVN_W;
    localparam int DW = rgbcf_pkg::DIVD_W;
    localparam int CW = rgbcf_pkg::DIVC_W;

    logic [NW-1:0] n_reg;
    logic [DW-1:0] r_reg, d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [DW:0]   trial, diff;
    logic          ge;

    // restoring division, one quotient bit a cycle
    assign trial = {r_reg, n_reg[NW-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    assign done = done_reg;
    assign quo  = n_reg;
    assign rem  = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                n_reg    <= num;
                r_reg    <= '0;
                d_reg    <= den;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                n_reg   <= {n_reg[NW-2:0], ge};
                r_reg   <= ge ? diff[DW-1:0] : trial[DW-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/core/rgbcf_back.sv */
module rgbcf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  rgbcf_pkg::cfg_t     cfg,
    input  logic                q_empty,
    output logic                q_pop,
    input  rgbcf_pkg::work_t    q_data,
    output logic                o_push,
    output rgbcf_pkg::result_t  o_data,
    input  logic                o_full
);

    localparam int SW = rgbcf_pkg::SUM_W;
    localparam int CW = rgbcf_pkg::CH_W;

    typedef enum logic [2:0] {
        S_IDLE, S_POS, S_MAC, S_CHDIV, S_CHWAIT, S_EDGE, S_EMIT
    } state_t;

    state_t state_reg;
    rgbcf_pkg::pixel_t [rgbcf_pkg::TAPS-1:0] win_reg;
    logic                 last_reg;
    logic                 top_ok_reg, bot_ok_reg, lft_ok_reg, rgt_ok_reg;
    logic [1:0]           trow_reg, tcol_reg, ch_reg;
    logic signed [SW-1:0] sum_reg [3];
    logic [CW-1:0]        res_reg [3];

    logic                          div_start, div_done;
    logic [rgbcf_pkg::DIVN_W-1:0]  div_num, div_quo;
    logic [rgbcf_pkg::DIVD_W-1:0]  div_den, div_rem;

    logic [3:0]                    tap_idx;
    logic signed [rgbcf_pkg::COEF_W-1:0] tap;
    rgbcf_pkg::pixel_t             tap_px;
    logic                          tap_use;
    logic signed [rgbcf_pkg::PROD_W-1:0] prod [3];
    logic signed [SW-1:0]          cur_sum;
    logic signed [rgbcf_pkg::EDGE_W-1:0] edge_sum;
    logic [rgbcf_pkg::ABS_W-1:0]   abs_sum;
    logic [SW-1:0]                 abs_ch [3];
    logic [33:0]                   third_prod;
    logic [16:0]                   third;
    logic [CW-1:0]                 edge_val;

    rgbcf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    assign cur_sum = sum_reg[ch_reg];
    assign q_pop   = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = q_data.pos;
        div_den   = cfg.w_eff;
        if (state_reg == S_IDLE)
        begin
            div_start = !q_empty;
        end
        else if (state_reg == S_CHDIV)
        begin
            div_start = cur_sum > 0;
            div_num   = rgbcf_pkg::DIVN_W'(unsigned'(cur_sum[SW-2:0]));
            div_den   = rgbcf_pkg::DIVD_W'(cfg.divisor);
        end
    end

    // one tap per cycle, all three channels at once
    assign tap_idx = 4'(trow_reg) * 4'd3 + 4'(tcol_reg);
    assign tap     = signed'(cfg.kernel[tap_idx * rgbcf_pkg::COEF_W +: rgbcf_pkg::COEF_W]);
    assign tap_px  = win_reg[tap_idx];
    assign tap_use = !((trow_reg == 2'd0) && !top_ok_reg) && !((trow_reg == 2'd2) && !bot_ok_reg)
                  && !((tcol_reg == 2'd0) && !lft_ok_reg) && !((tcol_reg == 2'd2) && !rgt_ok_reg);

    always_comb
    begin
        prod[0] = tap * signed'({1'b0, tap_px[23:16]});
        prod[1] = tap * signed'({1'b0, tap_px[15:8]});
        prod[2] = tap * signed'({1'b0, tap_px[7:0]});
    end

    // edge mode: threshold on the signed total, else mean of magnitudes
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            abs_ch[i] = sum_reg[i] < 0 ? SW'(-sum_reg[i]) : SW'(sum_reg[i]);
        end
        edge_sum   = rgbcf_pkg::EDGE_W'(sum_reg[0]) + rgbcf_pkg::EDGE_W'(sum_reg[1])
                   + rgbcf_pkg::EDGE_W'(sum_reg[2]);
        abs_sum    = rgbcf_pkg::ABS_W'(abs_ch[0]) + rgbcf_pkg::ABS_W'(abs_ch[1])
                   + rgbcf_pkg::ABS_W'(abs_ch[2]);
        third_prod = 34'(abs_sum) * 34'(rgbcf_pkg::THIRD_RECIP);
        third      = third_prod[33:rgbcf_pkg::THIRD_SHIFT];
        if (edge_sum > rgbcf_pkg::EDGE_W'(rgbcf_pkg::EDGE_THRESHOLD))
        begin
            edge_val = CW'(rgbcf_pkg::PIXEL_MAX);
        end
        else if (third > 17'(rgbcf_pkg::PIXEL_MAX))
        begin
            edge_val = CW'(rgbcf_pkg::PIXEL_MAX);
        end
        else
        begin
            edge_val = third[CW-1:0];
        end
    end

    assign o_push       = (state_reg == S_EMIT) && !o_full;
    assign o_data.red   = res_reg[0];
    assign o_data.green = res_reg[1];
    assign o_data.blue  = res_reg[2];
    assign o_data.last  = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            win_reg    <= '0;
            last_reg   <= 1'b0;
            top_ok_reg <= 1'b0;
            bot_ok_reg <= 1'b0;
            lft_ok_reg <= 1'b0;
            rgt_ok_reg <= 1'b0;
            trow_reg   <= '0;
            tcol_reg   <= '0;
            ch_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
                res_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        win_reg   <= q_data.win;
                        last_reg  <= q_data.last;
                        state_reg <= S_POS;
                    end
                end
                S_POS:
                begin
                    if (div_done)
                    begin
                        top_ok_reg <= div_quo != '0;
                        bot_ok_reg <= !(({1'b0, div_quo} + 1'b1) >= 28'(cfg.h_eff));
                        lft_ok_reg <= div_rem != '0;
                        rgt_ok_reg <= !(({1'b0, div_rem} + 1'b1) >= 12'(cfg.w_eff));
                        trow_reg   <= '0;
                        tcol_reg   <= '0;
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_reg[i] <= '0;
                        end
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    if (tap_use)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            sum_reg[i] <= sum_reg[i] + SW'(prod[i]);
                        end
                    end
                    if (tcol_reg == 2'd2)
                    begin
                        tcol_reg <= '0;
                        trow_reg <= trow_reg + 1'b1;
                        if (trow_reg == 2'd2)
                        begin
                            ch_reg    <= '0;
                            state_reg <= (cfg.divisor != '0) ? S_CHDIV : S_EDGE;
                        end
                    end
                    else
                    begin
                        tcol_reg <= tcol_reg + 1'b1;
                    end
                end
                S_CHDIV:
                begin
                    if (cur_sum > 0)
                    begin
                        state_reg <= S_CHWAIT;
                    end
                    else
                    begin
                        // non-positive quotient clamps to zero
                        res_reg[ch_reg] <= '0;
                        ch_reg          <= ch_reg + 1'b1;
                        state_reg       <= (ch_reg == 2'd2) ? S_EMIT : S_CHDIV;
                    end
                end
                S_CHWAIT:
                begin
                    if (div_done)
                    begin
                        res_reg[ch_reg] <= (div_quo > rgbcf_pkg::DIVN_W'(rgbcf_pkg::PIXEL_MAX))
                                         ? CW'(rgbcf_pkg::PIXEL_MAX) : div_quo[CW-1:0];
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= (ch_reg == 2'd2) ? S_EMIT : S_CHDIV;
                    end
                end
                S_EDGE:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        res_reg[i] <= edge_val;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!o_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == S_POS)
        else $error("popped work request not started");

    a_push_emit: assert property (@(posedge clk) disable iff (!rst_n)
        o_push |=> state_reg == S_IDLE)
        else $error("result push did not end the request");

    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHDIV || state_reg == S_CHWAIT) |-> ch_reg != 2'd3)
        else $error("channel counter out of range");

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 1024;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       fill;
    } pixel_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic [7:0] red_in = '0;
    logic [7:0] green_in = '0;
    logic [7:0] blue_in = '0;
    logic filler = 1'b0;
    logic pop = 1'b0;
    logic cfg_valid = 1'b0;
    logic [rgbcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [rgbcf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic full, empty, cfg_ready, last_of_frame;
    logic [7:0] red_out, green_out, blue_out;

    rgb_3x3_convolution_filter_top #(.MAX_WIDTH(LINE_DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .red_in(red_in), .green_in(green_in), .blue_in(blue_in), .filler(filler),
        .empty(empty), .pop(pop),
        .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
        .last_of_frame(last_of_frame),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // filter model state
    logic [rgbcf_pkg::PIX_W-1:0] row_above [LINE_DEPTH];
    logic [rgbcf_pkg::PIX_W-1:0] row_mid [LINE_DEPTH];
    logic [rgbcf_pkg::PIX_W-1:0] win [rgbcf_pkg::TAPS];
    int unsigned col_pos, row_pos, frame_count;
    logic [rgbcf_pkg::KERNEL_W-1:0] m_kernel;
    logic [rgbcf_pkg::DIVISOR_W-1:0] m_divisor;
    logic [rgbcf_pkg::FW_W-1:0] m_width;
    logic [rgbcf_pkg::FH_W-1:0] m_height;

    pixel_req_t pending_px[$];
    pixel_req_t cur_px;
    rgbcf_pkg::result_t filtered_q[$];
    int errors = 0;
    int accepted = 0;
    int send_idle = 0;
    int recv_idle = 0;

    task automatic filter_pixel(input pixel_req_t it);
        int we, he, c, h, w, a, x;
        int sum [3];
        logic [rgbcf_pkg::PIX_W-1:0] px, top, mid, q;
        longint p, total;
        logic signed [3:0] tap;
        rgbcf_pkg::result_t r;
        we = (m_width == 0) ? 1 : (m_width > LINE_DEPTH ? LINE_DEPTH : int'(m_width));
        he = (m_height == 0) ? 1 : int'(m_height);
        px = it.fill ? '0 : {it.red, it.green, it.blue};
        c = (col_pos >= LINE_DEPTH) ? 0 : col_pos;
        top = row_above[c];
        mid = row_mid[c];
        row_above[c] = mid;
        row_mid[c] = px;
        for (int i = 0; i < 3; i++)
        begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px;
        if (c + 1 >= we)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 16'hFFFF;
        end
        else
            col_pos = c + 1;
        if (frame_count < we + 1)
        begin
            frame_count = (frame_count + 1) & 27'h7FFFFFF;
            return;
        end
        p = longint'(frame_count) - (we + 1);
        total = longint'(we) * he;
        h = int'(p / we);
        w = int'(p % we);
        r.last = (p >= total - 1);
        sum = '{0, 0, 0};
        for (int i = 0; i < 3; i++)
        begin
            if ((i == 0 && h == 0) || (i == 2 && h + 1 >= he))
                continue;
            for (int k = 0; k < 3; k++)
            begin
                if ((k == 0 && w == 0) || (k == 2 && w + 1 >= we))
                    continue;
                q = win[i*3+k];
                tap = $signed(m_kernel[4*(i*3+k) +: 4]);
                for (int ch = 0; ch < 3; ch++)
                    sum[ch] += int'(tap) * int'(q[16-8*ch +: 8]);
            end
        end
        if (m_divisor != 0)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                x = sum[ch] / int'(m_divisor);
                x = (x < 0) ? 0 : (x > rgbcf_pkg::PIXEL_MAX ? rgbcf_pkg::PIXEL_MAX : x);
                if (ch == 0) r.red = x[7:0];
                else if (ch == 1) r.green = x[7:0];
                else r.blue = x[7:0];
            end
        end
        else
        begin
            if (sum[0] + sum[1] + sum[2] > rgbcf_pkg::EDGE_THRESHOLD)
                x = rgbcf_pkg::PIXEL_MAX;
            else
            begin
                a = 0;
                for (int ch = 0; ch < 3; ch++)
                    a += (sum[ch] < 0) ? -sum[ch] : sum[ch];
                x = a / 3;
                if (x > rgbcf_pkg::PIXEL_MAX) x = rgbcf_pkg::PIXEL_MAX;
            end
            r.red = x[7:0];
            r.green = x[7:0];
            r.blue = x[7:0];
        end
        filtered_q.push_back(r);
        if (r.last)
        begin
            frame_count = 0;
            col_pos = 0;
            row_pos = 0;
        end
        else
            frame_count = (frame_count + 1) & 27'h7FFFFFF;
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                filter_pixel(cur_px);
                accepted++;
            end
            if (!push || !full)
            begin
                if (pending_px.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    cur_px = pending_px.pop_front();
                    push <= 1'b1;
                    red_in <= cur_px.red;
                    green_in <= cur_px.green;
                    blue_in <= cur_px.blue;
                    filler <= cur_px.fill;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("unexpected result red=%0d green=%0d blue=%0d last=%0d",
                           red_out, green_out, blue_out, last_of_frame);
                    errors++;
                end
                else
                begin
                    rgbcf_pkg::result_t e;
                    e = filtered_q.pop_front();
                    if (red_out !== e.red)
                    begin
                        $error("red_out expected %0d got %0d", e.red, red_out);
                        errors++;
                    end
                    if (green_out !== e.green)
                    begin
                        $error("green_out expected %0d got %0d", e.green, green_out);
                        errors++;
                    end
                    if (blue_out !== e.blue)
                    begin
                        $error("blue_out expected %0d got %0d", e.blue, blue_out);
                        errors++;
                    end
                    if (last_of_frame !== e.last)
                    begin
                        $error("last_of_frame expected %0d got %0d", e.last, last_of_frame);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // call right after a rising edge; leaves cfg_valid high
    task automatic write_reg(input logic [rgbcf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rgbcf_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rgbcf_pkg::REG_KERNEL:  m_kernel = val[rgbcf_pkg::KERNEL_W-1:0];
            rgbcf_pkg::REG_DIVISOR: m_divisor = val[rgbcf_pkg::DIVISOR_W-1:0];
            rgbcf_pkg::REG_WIDTH:   m_width = val[rgbcf_pkg::FW_W-1:0];
            rgbcf_pkg::REG_HEIGHT:  m_height = val[rgbcf_pkg::FH_W-1:0];
            default:                m_kernel = m_kernel;
        endcase
    endtask

    task automatic configure(input logic [rgbcf_pkg::KERNEL_W-1:0] kern, input int dv,
                             input int wd, input int ht);
        @(posedge clk);
        write_reg(rgbcf_pkg::REG_KERNEL, kern);
        write_reg(rgbcf_pkg::REG_DIVISOR, rgbcf_pkg::CFG_DATA_W'(dv));
        write_reg(rgbcf_pkg::REG_WIDTH, rgbcf_pkg::CFG_DATA_W'(wd));
        write_reg(rgbcf_pkg::REG_HEIGHT, rgbcf_pkg::CFG_DATA_W'(ht));
        cfg_valid <= 1'b0;
    endtask

    task automatic add_pixel(input int rv, input int gv, input int bv, input bit fl);
        pixel_req_t it;
        it.red = rv[7:0];
        it.green = gv[7:0];
        it.blue = bv[7:0];
        it.fill = fl;
        pending_px.push_back(it);
    endtask

    task automatic add_rand(input bit fl);
        add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), fl);
    endtask

    // one frame plus its flush; broken frames mix in stray fillers,
    // pixel data in the flush, or stop short
    task automatic add_frame(input int wd, input int ht, input bit broken);
        int n;
        n = wd * ht;
        if (broken && $urandom_range(1))
            n = $urandom_range(n);
        for (int i = 0; i < n; i++)
            add_rand(broken && $urandom_range(7) == 0);
        if (!broken || $urandom_range(1))
            for (int i = 0; i <= wd; i++)
                add_rand(broken ? $urandom_range(1) : 1'b1);
    endtask

    task automatic drain;
        wait (pending_px.size() == 0 && !push);
        wait (filtered_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [rgbcf_pkg::KERNEL_W-1:0] pick_kernel;
        case ($urandom_range(7))
            0: return 36'h111111111;
            1: return 36'h121242121;
            2: return 36'h10F20E10F;
            3: return 36'hFEF000121;
            4: return 36'h888888888;
            5: return 36'h777777777;
            default: return {4'($urandom_range(15)), $urandom};
        endcase
    endfunction

    function automatic int pick_divisor;
        case ($urandom_range(5))
            0: return 0;
            1: return 1;
            2: return 9;
            3: return 16;
            4: return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    initial
    begin
        int wd, ht;
        for (int i = 0; i < LINE_DEPTH; i++)
        begin
            row_above[i] = '0;
            row_mid[i] = '0;
        end
        for (int i = 0; i < rgbcf_pkg::TAPS; i++)
            win[i] = '0;
        col_pos = 0;
        row_pos = 0;
        frame_count = 0;
        m_kernel = rgbcf_pkg::KERNEL_RESET;
        m_divisor = rgbcf_pkg::DIVISOR_RESET;
        m_width = rgbcf_pkg::WIDTH_RESET;
        m_height = rgbcf_pkg::HEIGHT_RESET;
        send_idle = 20;
        recv_idle = 55;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // edge mode with extreme pixels, 3x2 frame
        configure(36'h10F20E10F, 0, 3, 2);
        add_pixel(255, 255, 255, 0);
        add_pixel(0, 0, 0, 0);
        add_pixel(255, 0, 255, 0);
        add_pixel(0, 255, 0, 0);
        add_pixel(255, 255, 255, 0);
        add_pixel(0, 0, 0, 1);
        repeat (4) add_pixel(255, 255, 255, 1);
        drain();
        // zero width and height act as 1; most negative taps clamp to 0
        configure(36'h888888888, 1, 0, 0);
        add_pixel(255, 255, 255, 0);
        add_pixel(255, 255, 255, 1);
        add_pixel(17, 200, 3, 0);
        add_pixel(255, 255, 255, 0);
        repeat (2) add_pixel(0, 0, 0, 1);
        drain();
        // tall frame left unfinished, then width change mid-frame
        configure(36'h777777777, 255, 2, 65535);
        repeat (5) add_rand(0);
        drain();
        configure(36'h121242121, 16, 1, 1);
        repeat (3) add_rand(0);
        drain();

        while (accepted < 1200)
        begin
            if (accepted >= 800)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (accepted >= 400)
            begin
                send_idle = 55;
                recv_idle = 20;
            end
            wd = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(1, 8);
            ht = $urandom_range(1, 5);
            configure(pick_kernel(), pick_divisor(), wd, ht);
            for (int f = $urandom_range(1, 3); f > 0; f--)
                add_frame(wd, ht, $urandom_range(4) == 0);
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("tb: failure");
        $finish;
    end
endmodule
